// ----- hdl/b2s_pkg.sv -----
//------------------------------------------------------------------------------
// b2s_pkg
// Shared types, constants and tables of the BLAKE2s hash engine.
//------------------------------------------------------------------------------
package b2s_pkg;

   localparam int DIGEST_BYTES_DEFAULT = 32;
   localparam logic [31:0] PARAM_BASE = 32'h0101_0000;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // latch the accepted input word
      logic absorb;       // append bytes of the input word
      logic init_v;       // load work vector for a compression
      logic final_blk;    // last-block flag for init
      logic add_count;    // raise counter by 64 (full block)
      logic add_fill;     // raise counter by buffered bytes
      logic pad;          // zero the unused part of the block
      logic round_step;   // one half-round of G mixing
      logic finish;       // fold work vector into chain value
      logic reload;       // reload IV xor parameter
      logic clr_fill;     // clear fill after a compression
   } b2s_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       full;       // buffer holds 64 bytes
      logic       empty;      // nothing absorbed since reload
      logic       pending;    // held word still has bytes to absorb
      logic       fits;       // remaining bytes fit in the buffer
      logic       last;       // held word ends the message
      logic [5:0] len;        // digest length in use
   } b2s_sts_type;

   function automatic logic [31:0] iv_word(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'h6A09E667;
         3'd1: r = 32'hBB67AE85;
         3'd2: r = 32'h3C6EF372;
         3'd3: r = 32'hA54FF53A;
         3'd4: r = 32'h510E527F;
         3'd5: r = 32'h9B05688C;
         3'd6: r = 32'h1F83D9AB;
         default: r = 32'h5BE0CD19;
      endcase
      return r;
   endfunction

   // message schedule, rounds 0..9, flattened nibbles (entry 0 in the low bits)
   function automatic logic [63:0] perm_row(input logic [3:0] r);
      logic [63:0] p;
      case (r)
         4'd0: p = 64'hFEDCBA9876543210;
         4'd1: p = 64'h357B20C16DF984AE;
         4'd2: p = 64'h491763EADF250C8B;
         4'd3: p = 64'h8F04A562EBCD1397;
         4'd4: p = 64'hD386CB1EFA427509;
         4'd5: p = 64'h91EF57D438B0A6C2;
         4'd6: p = 64'hB8293670A4DEF15C;
         4'd7: p = 64'hA2684F05931CE7BD;
         4'd8: p = 64'h5A417D2C803B9EF6;
         default: p = 64'h0DC3E9BF5167482A;
      endcase
      return p;
   endfunction

   function automatic logic [5:0] clamp_len(input logic [5:0] v);
      logic [5:0] r;
      if (v == 6'd0) r = 6'd1;
      else if (v > 6'd32) r = 6'd32;
      else r = v;
      return r;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- hdl/blake2s_hash_engine.sv -----
//------------------------------------------------------------------------------
// blake2s_hash_engine
// Unkeyed BLAKE2s hash with configurable digest length.
//------------------------------------------------------------------------------
// Usage:
//   req_* : message words, up to four bytes each, first byte in bits 7:0.
//           Mark the final word with last; only it may carry < 4 bytes.
//   rsp_* : digest words, ceil(len/4) of them, last_word on the final one.
//   csr_* : digest length in bytes (1..32), written while idle.
// Sequence: a word is accepted, then absorbed. A word that follows a
//   full block first runs one compression: a counter step, the init,
//   the half-rounds (the four G lanes are shared by columns and
//   diagonals) and a fold. A last word adds a pad step and a
//   compression after the absorb, before the first digest word.
// The digest is held in the chain registers and presented one word per
//   cycle; a stalled rsp_ready simply holds the current word.
// Reset: chain value reloaded to IV xor parameter for a 32 byte digest,
//   counter and buffer cleared; ready is low during reset and high as
//   soon as reset is released.
//------------------------------------------------------------------------------
module blake2s_hash_engine
   import b2s_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [5:0]   csr_data
);

   b2s_cmd_type cmd;
   b2s_sts_type sts;
   logic [3:0]  round_idx;
   logic        diag;
   logic [2:0]  out_idx;
   logic        out_last;
   logic [31:0] out_word;

   b2s_control u_ctl (
      .clock, .reset, .req_valid, .req_ready,
      .rsp_valid, .rsp_ready, .csr_ready, .sts, .cmd,
      .round_idx, .diag, .out_idx, .out_last
   );

   // datapath latches the input word on accept
   b2s_datapath u_dp (
      .clock, .reset, .cmd, .round_idx, .diag,
      .req_word,
      .csr_valid, .csr_data, .csr_ready,
      .out_idx, .out_word, .sts
   );

   assign rsp_word = '{digest_word: out_word, word_index: out_idx,
                       last_word: out_last};

endmodule

// ----- hdl/b2s_datapath.sv -----
//------------------------------------------------------------------------------
// b2s_datapath
// Block buffer, counter, chain value and the four-lane G mixing unit.
//------------------------------------------------------------------------------
module b2s_datapath
   import b2s_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  b2s_cmd_type  cmd,
   input  logic [3:0]   round_idx,
   input  logic         diag,
   input  req_word_type req_word,
   input  logic         csr_valid,
   input  logic [5:0]   csr_data,
   input  logic         csr_ready,
   input  logic [2:0]   out_idx,
   output logic [31:0]  out_word,
   output b2s_sts_type  sts
);

   logic [31:0] cv_ff [8];
   logic [31:0] v_ff [16];
   logic [31:0] m_ff [16];
   logic [63:0] cnt_ff;
   logic [6:0]  fill_ff;
   logic [5:0]  dbytes_ff;
   logic [5:0]  len_ff;
   logic [31:0] word_ff;
   logic [2:0]  left_ff;
   logic        last_ff;

   logic [2:0]  nbytes;
   logic [5:0]  new_len;
   logic [6:0]  avail;
   logic        fits;
   logic [2:0]  take;

   assign nbytes  = (req_word.byte_count > 3'd4) ? 3'd4 : req_word.byte_count;
   assign new_len = clamp_len(csr_data);
   // a word may straddle the block edge after a short non-last word
   assign avail   = 7'd64 - fill_ff;
   assign fits    = ({4'd0, left_ff} <= avail);
   assign take    = fits ? left_ff : avail[2:0];
   assign sts = '{full:    (fill_ff == 7'd64),
                  empty:   (fill_ff == 7'd0) && (cnt_ff == 64'd0),
                  pending: (left_ff != 3'd0),
                  fits:    fits,
                  last:    last_ff,
                  len:     len_ff};

   // G function on one column or diagonal
   function automatic logic [127:0] gfun(input logic [31:0] a, b, c, d, x, y);
      logic [31:0] a1, b1, c1, d1;
      a1 = a + b + x;
      d1 = rotr(d ^ a1, 16);
      c1 = c + d1;
      b1 = rotr(b ^ c1, 12);
      a1 = a1 + b1 + y;
      d1 = rotr(d1 ^ a1, 8);
      c1 = c1 + d1;
      b1 = rotr(b1 ^ c1, 7);
      return {a1, b1, c1, d1};
   endfunction

   logic [63:0]  prow;
   logic [127:0] g_res [4];
   logic [3:0]   ia [4], ib [4], ic [4], id [4];

   always_comb begin
      prow = perm_row(round_idx);
      for (int k = 0; k < 4; k++) begin
         ia[k] = 4'(k);
         if (!diag) begin
            ib[k] = 4'(k + 4);
            ic[k] = 4'(k + 8);
            id[k] = 4'(k + 12);
         end else begin
            ib[k] = 4'(((k + 1) % 4) + 4);
            ic[k] = 4'(((k + 2) % 4) + 8);
            id[k] = 4'(((k + 3) % 4) + 12);
         end
         g_res[k] = gfun(v_ff[ia[k]], v_ff[ib[k]], v_ff[ic[k]], v_ff[id[k]],
            m_ff[prow[(diag ? 32 : 0) + k*8 +: 4]],
            m_ff[prow[(diag ? 32 : 0) + k*8 + 4 +: 4]]);
      end
   end

   logic [31:0] cw;
   assign cw = cv_ff[out_idx];
   always_comb begin
      out_word = cw;
      if (len_ff < 6'({out_idx, 2'b00}) + 6'd4) begin
         case (2'(len_ff - 6'({out_idx, 2'b00})))
            2'd1:    out_word = {24'd0, cw[7:0]};
            2'd2:    out_word = {16'd0, cw[15:0]};
            2'd3:    out_word = {8'd0, cw[23:0]};
            default: out_word = cw;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbytes_ff <= 6'd32;
         len_ff    <= 6'd32;
         cnt_ff    <= '0;
         fill_ff   <= '0;
         word_ff   <= '0;
         left_ff   <= '0;
         last_ff   <= 1'b0;
         for (int i = 0; i < 8; i++)
            cv_ff[i] <= iv_word(3'(i)) ^ ((i == 0) ? (PARAM_BASE | 32'd32) : 32'd0);
         for (int i = 0; i < 16; i++) m_ff[i] <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            dbytes_ff <= csr_data;
            if (sts.empty) begin
               len_ff   <= new_len;
               cv_ff[0] <= iv_word(3'd0) ^ PARAM_BASE ^ {26'd0, new_len};
            end
         end
         if (cmd.load) begin
            word_ff <= req_word.data_word;
            left_ff <= nbytes;
            last_ff <= req_word.last;
         end
         if (cmd.add_count) cnt_ff <= cnt_ff + 64'd64;
         if (cmd.add_fill)  cnt_ff <= cnt_ff + {57'd0, fill_ff};
         if (cmd.clr_fill)  fill_ff <= '0;
         if (cmd.absorb) begin
            for (int j = 0; j < 4; j++) begin
               if (3'(j) < take)
                  m_ff[4'((fill_ff + 7'(j)) >> 2)][8*2'(fill_ff[1:0] + 2'(j)) +: 8]
                     <= word_ff[8*j +: 8];
            end
            word_ff <= word_ff >> {take, 3'b000};
            left_ff <= left_ff - take;
            fill_ff <= fill_ff + 7'(take);
         end
         if (cmd.pad) begin
            for (int i = 0; i < 16; i++) begin
               if (7'(4*i) >= fill_ff) m_ff[i] <= '0;
               else if (7'(4*i + 4) > fill_ff)
                  case (2'(fill_ff))
                     2'd1:    m_ff[i] <= {24'd0, m_ff[i][7:0]};
                     2'd2:    m_ff[i] <= {16'd0, m_ff[i][15:0]};
                     default: m_ff[i] <= {8'd0, m_ff[i][23:0]};
                  endcase
            end
         end
         if (cmd.finish)
            for (int i = 0; i < 8; i++) cv_ff[i] <= cv_ff[i] ^ v_ff[i] ^ v_ff[i + 8];
         if (cmd.reload) begin
            len_ff <= clamp_len(dbytes_ff);
            cnt_ff <= '0;
            fill_ff <= '0;
            for (int i = 0; i < 8; i++)
               cv_ff[i] <= iv_word(3'(i)) ^
                  ((i == 0) ? (PARAM_BASE | {26'd0, clamp_len(dbytes_ff)}) : 32'd0);
            for (int i = 0; i < 16; i++) m_ff[i] <= '0;
         end
      end
   end

   // work vector, no reset
   always_ff @(posedge clock) begin
      if (cmd.init_v) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= cv_ff[i];
         for (int i = 0; i < 4; i++) v_ff[i + 8] <= iv_word(3'(i));
         v_ff[12] <= iv_word(3'd4) ^ cnt_ff[31:0];
         v_ff[13] <= iv_word(3'd5) ^ cnt_ff[63:32];
         v_ff[14] <= iv_word(3'd6) ^ {32{cmd.final_blk}};
         v_ff[15] <= iv_word(3'd7);
      end else if (cmd.round_step) begin
         for (int k = 0; k < 4; k++) begin
            v_ff[ia[k]] <= g_res[k][127:96];
            v_ff[ib[k]] <= g_res[k][95:64];
            v_ff[ic[k]] <= g_res[k][63:32];
            v_ff[id[k]] <= g_res[k][31:0];
         end
      end
   end

endmodule

// ----- hdl/b2s_control.sv -----
//------------------------------------------------------------------------------
// b2s_control
// Sequencer: absorb, compress (20 half-rounds), pad and digest output.
//------------------------------------------------------------------------------
module b2s_control
   import b2s_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         csr_ready,
   input  b2s_sts_type  sts,
   output b2s_cmd_type  cmd,
   output logic [3:0]   round_idx,
   output logic         diag,
   output logic [2:0]   out_idx,
   output logic         out_last
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_INIT   = 7'b0000010,
      S_ROUND  = 7'b0000100,
      S_FOLD   = 7'b0001000,
      S_ABSORB = 7'b0010000,
      S_PAD    = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic        diag_ff, diag_in;
   logic        fin_ff, fin_in;     // compressing the final block
   logic [2:0]  oidx_ff, oidx_in;
   logic [2:0]  nwords;

   assign nwords = 3'((sts.len + 6'd3) >> 2) - 3'd1; // last index
   assign round_idx = rnd_ff;
   assign diag      = diag_ff;
   assign out_idx   = oidx_ff;
   assign out_last  = (oidx_ff == nwords);
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign csr_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      diag_in  = diag_ff;
      fin_in   = fin_ff;
      oidx_in  = oidx_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               fin_in = 1'b0;
               state_in = S_ABSORB;
            end
         end
         S_ABSORB: begin
            // a full buffer is compressed only once another byte arrives
            if (sts.full && sts.pending) begin
               cmd.add_count = 1'b1;
               state_in = S_INIT;
            end else begin
               cmd.absorb = 1'b1;
               if (!sts.fits) state_in = S_ABSORB;
               else state_in = sts.last ? S_PAD : S_IDLE;
            end
         end
         S_PAD: begin
            cmd.pad      = 1'b1;
            cmd.add_fill = 1'b1;
            fin_in = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init_v    = 1'b1;
            cmd.final_blk = fin_ff;
            rnd_in  = '0;
            diag_in = 1'b0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            diag_in = !diag_ff;
            if (diag_ff) begin
               rnd_in = rnd_ff + 4'd1;
               if (rnd_ff == 4'd9) state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.finish = 1'b1;
            oidx_in = '0;
            if (fin_ff) state_in = S_OUT;
            else begin
               cmd.clr_fill = 1'b1;
               state_in = S_ABSORB;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (out_last) begin
                  cmd.reload = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rnd_ff   <= '0;
         diag_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         diag_ff  <= diag_in;
         fin_ff   <= fin_in;
         oidx_ff  <= oidx_in;
      end
   end

endmodule

// ----- hdl/b2s_checker.sv -----
//------------------------------------------------------------------------------
// b2s_checker
// Port-level checks of the hash engine.
//------------------------------------------------------------------------------
module b2s_checker
   import b2s_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word,
   input logic         csr_ready
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input open during digest");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("digest word changed while stalled");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_word.last_word |=>
         rsp_valid && rsp_word.word_index == $past(rsp_word.word_index) + 3'd1)
      else $error("digest index skipped");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word.word_index == 3'd0)
      else $error("digest does not start at word 0");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> req_ready) else $error("csr open while busy");

endmodule

bind blake2s_hash_engine b2s_checker u_chk (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_word, .csr_ready
);
